// ===== sv/pus_pkg.sv =====
// Shared constants and types for the PNG RGB8 scanline unfilter.
package pus_pkg;

  // Row storage geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ROW_BYTES = 3 * MAX_WIDTH;
  localparam int POS_W     = $clog2(ROW_BYTES);
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_WIDTH);

  // Filter type codes
  localparam logic [2:0] FLT_NONE    = 3'd0;
  localparam logic [2:0] FLT_SUB     = 3'd1;
  localparam logic [2:0] FLT_UP      = 3'd2;
  localparam logic [2:0] FLT_AVERAGE = 3'd3;
  localparam logic [2:0] FLT_PAETH   = 3'd4;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // One data byte handed from the front end to the reconstruction stage
  typedef struct packed {
    logic [7:0]       data;
    logic [1:0]       channel;
    logic [2:0]       filter;
    logic             first_col;
    logic             first_row;
    logic             end_of_row;
    logic             end_of_image;
    logic [POS_W-1:0] pos;
  } pus_item_t;

endpackage

// ===== sv/pus_in_if.sv =====
// Filtered byte stream channel.
interface pus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== sv/pus_out_if.sv =====
// Reconstructed pixel byte channel.
interface pus_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [1:0] channel;
  logic       end_of_row;
  logic       end_of_image;

  modport source (output valid, output pixel_byte, output channel, output end_of_row,
                  output end_of_image, input ready);
  modport sink (input valid, input pixel_byte, input channel, input end_of_row,
                input end_of_image, output ready);
endinterface

// ===== sv/pus_cfg_if.sv =====
// Register write channel.
interface pus_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== sv/png_rgb8_scanline_unfilter.sv =====
// Top level of the PNG RGB8 scanline unfilter.
//
// Usage: feed the inflated, filtered stream on in_ch one byte per item. The
// first byte of each row is the filter type and yields no item on out_ch; each
// later byte yields one reconstructed byte with its channel and end-of-row and
// end-of-image marks. Image width and height are set through cfg_ch (index 0
// width, index 1 height) between images; cfg_ch is always ready.
// Data path: the edge that accepts a data byte also reads the previous-row
// memory into the up register; once the output register is free, the byte
// is reconstructed and loaded into the output register.
// Throughput: one byte per cycle while out_ch is ready, set by the single read and
// single write port of the 3072-byte row memory, which serve one byte each per cycle.
// Reset: clears the counters, expects a filter byte next, and sets width and
// height to 1. The row memory is not cleared; row 0 ignores what it reads.
// Stall: when out_ch is not ready the output register holds, one more item
// waits in the reconstruction stage, and in_ch drops ready.
module png_rgb8_scanline_unfilter
  import pus_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pus_in_if.sink    in_ch,
  pus_out_if.source out_ch,
  pus_cfg_if.sink   cfg_ch
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                awaiting_r;
  logic [2:0]          filter_r;
  logic [COL_W-1:0]    col_r;
  logic [1:0]          ch_r;
  logic [HEIGHT_W-1:0] row_r;

  logic                stage_ready;
  logic                accept;
  logic                load;
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic                last_col;
  logic                last_row;
  pus_item_t           item;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_ch.reg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_ch.reg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to its legal range
  always_comb begin
    if (width_r == '0) width_eff = WIDTH_W'(1);
    else if (width_r > WIDTH_MAX) width_eff = WIDTH_MAX;
    else width_eff = width_r;
    height_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    last_col   = {{(WIDTH_W-COL_W){1'b0}}, col_r} >= (width_eff - WIDTH_W'(1));
    last_row   = row_r >= (height_eff - HEIGHT_W'(1));
  end

  assign in_ch.ready = stage_ready;
  assign accept      = in_ch.valid && stage_ready;
  assign load        = accept && !awaiting_r;

  // Build the item for the reconstruction stage
  always_comb begin
    item.data         = in_ch.stream_byte;
    item.channel      = ch_r;
    item.filter       = filter_r;
    item.first_col    = (col_r == '0);
    item.first_row    = (row_r == '0);
    item.end_of_row   = last_col && (ch_r == CH_BLUE);
    item.end_of_image = last_col && (ch_r == CH_BLUE) && last_row;
    item.pos          = POS_W'({col_r, 1'b0}) + POS_W'(col_r) + POS_W'(ch_r);
  end

  // Advance row, column and channel counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      filter_r   <= FLT_NONE;
      col_r      <= '0;
      ch_r       <= CH_RED;
      row_r      <= '0;
    end else if (accept) begin
      if (awaiting_r) begin
        awaiting_r <= 1'b0;
        filter_r   <= (in_ch.stream_byte <= 8'(FLT_PAETH)) ? in_ch.stream_byte[2:0]
                                                            : FLT_NONE;
        col_r      <= '0;
        ch_r       <= CH_RED;
      end else if (ch_r != CH_BLUE) begin
        ch_r <= ch_r + 2'd1;
      end else begin
        ch_r <= CH_RED;
        if (last_col) begin
          col_r      <= '0;
          awaiting_r <= 1'b1;
          row_r      <= last_row ? '0 : row_r + HEIGHT_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  pus_recon u_recon (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .item_in     (item),
    .stage_ready (stage_ready),
    .out_ch      (out_ch)
  );

endmodule

// ===== sv/pus_recon.sv =====
// Row memory, neighbor registers, predictor and output register.
module pus_recon
  import pus_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pus_item_t        item_in,
  output logic             stage_ready,
  pus_out_if.source        out_ch
);

  logic [7:0] row_mem [ROW_BYTES];
  logic [7:0] up_r;
  pus_item_t  item_r;
  logic       item_valid_r;
  logic [7:0] left_r [3];
  logic [7:0] upleft_r [3];
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_channel_r;
  logic       out_eor_r;
  logic       out_eoi_r;

  logic       advance;
  logic [7:0] nb_a, nb_b, nb_c, pred, value;
  logic [8:0] sum_ab;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] db, da, dab;
    logic [9:0] pa, pb, pc;
    begin
      db  = $signed({2'b00, b}) - $signed({2'b00, c});
      da  = $signed({2'b00, a}) - $signed({2'b00, c});
      dab = db + da;
      pa  = db[9] ? 10'(-db) : 10'(db);
      pb  = da[9] ? 10'(-da) : 10'(da);
      pc  = dab[9] ? 10'(-dab) : 10'(dab);
      if (pa <= pb && pa <= pc) paeth = a;
      else if (pb <= pc) paeth = b;
      else paeth = c;
    end
  endfunction

  // Move the held item on once the output register is free
  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign stage_ready = !item_valid_r || advance;

  // Read the byte above when the item enters
  always_ff @(posedge clk) begin
    if (load) begin
      up_r <= row_mem[item_in.pos];
    end
  end

  // Write the reconstructed byte back for the next row
  always_ff @(posedge clk) begin
    if (advance) begin
      row_mem[item_r.pos] <= value;
    end
  end

  // Hold the item while its row byte is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (load) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  // Gather neighbors, zero outside the image
  always_comb begin
    nb_a   = item_r.first_col ? 8'd0 : left_r[item_r.channel];
    nb_b   = item_r.first_row ? 8'd0 : up_r;
    nb_c   = (item_r.first_col || item_r.first_row) ? 8'd0 : upleft_r[item_r.channel];
    sum_ab = {1'b0, nb_a} + {1'b0, nb_b};
    case (item_r.filter)
      FLT_SUB:     pred = nb_a;
      FLT_UP:      pred = nb_b;
      FLT_AVERAGE: pred = sum_ab[8:1];
      FLT_PAETH:   pred = paeth(nb_a, nb_b, nb_c);
      default:     pred = 8'd0;
    endcase
    value = item_r.data + pred;
  end

  // Keep last byte and its upper byte per channel
  always_ff @(posedge clk) begin
    if (advance) begin
      left_r[item_r.channel]   <= value;
      upleft_r[item_r.channel] <= nb_b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r    <= value;
      out_channel_r <= item_r.channel;
      out_eor_r     <= item_r.end_of_row;
      out_eoi_r     <= item_r.end_of_image;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_byte   = out_byte_r;
  assign out_ch.channel      = out_channel_r;
  assign out_ch.end_of_row   = out_eor_r;
  assign out_ch.end_of_image = out_eoi_r;

endmodule
